>>> sv/glss_pkg.sv
package glss_pkg;

  localparam int ROWS_A    = 4096;
  localparam int COLS_B    = 65536;
  localparam int FRAC_BITS = 16;

  localparam int ROW_IW    = 12;
  localparam int COL_IW    = 16;
  localparam int ROW_AW    = (ROWS_A > 1) ? $clog2(ROWS_A) : 1;
  localparam int COL_LANES = 32;
  localparam int COL_WORDS = (COLS_B + COL_LANES - 1) / COL_LANES;
  localparam int COL_AW    = (COL_WORDS > 1) ? $clog2(COL_WORDS) : 1;
  localparam int CLR_LEN   = (ROWS_A > COL_WORDS) ? ROWS_A : COL_WORDS;
  localparam int CLR_AW    = $clog2(CLR_LEN);

  localparam int NB_W    = 17;
  localparam int LL_W    = 48;
  localparam int CNT_W   = 13;
  localparam int N_W     = 17;
  localparam int DSUM_W  = 34;
  localparam int DELTA_W = 36;
  localparam int ROWW    = 1 + COL_IW;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

  localparam logic [1:0] CFG_NB_COUNT = 2'd0;
  localparam logic [1:0] CFG_PRIOR    = 2'd1;
  localparam logic [1:0] CFG_START_LL = 2'd2;

  typedef struct packed {
    logic                      start;
    logic [N_W-1:0]            n;
    logic signed [DSUM_W-1:0]  dsum;
    logic                      del;
    logic [31:0]               draw;
  } math_req_t;

  typedef struct packed {
    logic                      done;
    logic                      accept;
    logic signed [DELTA_W-1:0] delta;
  } math_rsp_t;

  // floor square root, digit by digit
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x    = x_in;
    res  = 64'd0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q0.32 values of 2^(-2^-i), i = 1..FRAC_BITS
  function automatic logic [FRAC_BITS-1:0][31:0] rtab_make();
    logic [FRAC_BITS-1:0][31:0] tab;
    logic [63:0] r;
    r = isqrt64(64'h8000_0000_0000_0000);
    for (int i = 0; i < FRAC_BITS; i++) begin
      tab[i] = r[31:0];
      r = isqrt64({r[31:0], 32'd0});
    end
    return tab;
  endfunction

  localparam logic [FRAC_BITS-1:0][31:0] RTAB = rtab_make();

endpackage

>>> sv/glss_ram.sv
module glss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/glss_math.sv
// ln(n), delta, sigmoid and acceptance test on one shared multiplier
// plus a one-bit-per-cycle divider.
module glss_math (
  input  logic                clk,
  input  logic                rst,
  input  glss_pkg::math_req_t req,
  output glss_pkg::math_rsp_t rsp
);

  localparam int F   = glss_pkg::FRAC_BITS;
  localparam int DW  = glss_pkg::DELTA_W;
  localparam int TW  = F + 6;
  localparam int EW  = (F > 1) ? $clog2(F) : 1;
  localparam int SH  = 56 - F;
  localparam logic [61:0] RND = 62'(64'd1 << (55 - F));
  localparam logic [DW-1:0] CAP = DW'(64'd40 << F);

  typedef enum logic [3:0] {
    M_IDLE, M_SQ, M_LNMUL, M_SIGMUL, M_EXP, M_SHIFT, M_DIV, M_DONE
  } mstate_t;

  mstate_t                       state;
  logic [5:0]                    cnt;
  logic [31:0]                   y;
  logic [23:0]                   frac;
  logic [4:0]                    k;
  logic signed [glss_pkg::DSUM_W-1:0] dsum;
  logic                          del;
  logic [31:0]                   draw;
  logic signed [DW-1:0]          delta;
  logic [5:0]                    ti;
  logic [F-1:0]                  tf;
  logic [32:0]                   m;
  logic [33:0]                   dvs;
  logic [34:0]                   rem;
  logic [31:0]                   q;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  logic [4:0]  k_next;
  logic [32:0] sq;
  logic [31:0] lnr;
  logic signed [DW-1:0] delta_next;
  logic [DW-1:0] amag;
  logic [TW-1:0] t;
  logic [35:0] rem2;
  logic [32:0] q2;
  logic [32:0] p;

  always_comb begin
    k_next = 5'd0;
    for (int i = 0; i < glss_pkg::N_W; i++) begin
      if (req.n[i]) k_next = 5'(i);
    end
    amag = delta[DW-1] ? DW'(-delta) : DW'(delta);
    if (amag > CAP) amag = CAP;
    case (state)
      M_SQ:     begin mul_a = {1'b0, y};    mul_b = y; end
      M_LNMUL:  begin mul_a = 33'({k, frac}); mul_b = glss_pkg::LN2_Q32; end
      M_SIGMUL: begin mul_a = 33'(amag);    mul_b = glss_pkg::LOG2E_Q30; end
      M_EXP:    begin mul_a = m;            mul_b = glss_pkg::RTAB[cnt[EW-1:0]]; end
      default:  begin mul_a = 33'd0;        mul_b = 32'd0; end
    endcase
    prod = 65'(mul_a) * 65'(mul_b);
    sq   = prod[63:31];
    lnr  = 32'((prod[61:0] + RND) >> SH);
    delta_next = DW'(dsum) - DW'($signed({1'b0, lnr}));
    if (del) delta_next = -delta_next;
    t    = TW'(prod >> 30);
    rem2 = {rem, 1'b0};
    q2   = {q, 1'b0};
    p    = delta[DW-1] ? (33'h1_0000_0000 - q2) : q2;
    rsp.done   = (state == M_DONE);
    rsp.accept = ({1'b0, draw} < p);
    rsp.delta  = delta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= 6'd0;
    end else begin
      case (state)
        M_IDLE: begin
          if (req.start) begin
            k     <= k_next;
            y     <= 32'(req.n) << (5'd31 - k_next);
            frac  <= 24'd0;
            dsum  <= req.dsum;
            del   <= req.del;
            draw  <= req.draw;
            cnt   <= 6'd0;
            state <= M_SQ;
          end
        end
        M_SQ: begin
          frac <= {frac[22:0], sq[32]};
          y    <= sq[32] ? sq[32:1] : sq[31:0];
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd23) state <= M_LNMUL;
        end
        M_LNMUL: begin
          delta <= delta_next;
          state <= M_SIGMUL;
        end
        M_SIGMUL: begin
          ti    <= t[TW-1:F];
          tf    <= t[F-1:0];
          m     <= 33'h1_0000_0000;
          cnt   <= 6'd0;
          state <= M_EXP;
        end
        M_EXP: begin
          if (tf[F-1]) m <= prod[64:32];
          tf  <= tf << 1;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(F - 1)) state <= M_SHIFT;
        end
        M_SHIFT: begin
          dvs   <= 34'h1_0000_0000 + 34'((ti >= 6'd32) ? 33'd0 : (m >> ti[4:0]));
          rem   <= 35'h0_8000_0000;
          q     <= 32'd0;
          cnt   <= 6'd0;
          state <= M_DIV;
        end
        M_DIV: begin
          if (rem2 >= 36'(dvs)) begin
            rem <= 35'(rem2 - 36'(dvs));
            q   <= {q[30:0], 1'b1};
          end else begin
            rem <= rem2[34:0];
            q   <= {q[30:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) state <= M_DONE;
        end
        M_DONE:  state <= M_IDLE;
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

>>> sv/gibbs_link_sweep_step_unit.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | row_index col_index lla llb lll uniform_draw
// out     | output    | out_valid/out_stall| linked_after changed loglik_now link_total
// cfg     | input     | cfg_valid/cfg_ready| cfg_index cfg_data
//
// A pair that proposes a change runs 24 squaring steps for the log2 fraction of the
// count and 16 exponent steps on the shared multiplier, then 32 steps of the
// restoring divider for the sigmoid, plus a write state when the link is made or
// broken. A pair that proposes nothing goes from the store read straight to the
// result. After reset the stores are swept clear over max(ROWS_A, COLS_B/32)
// addresses (4096), with in_stall high; config writes are taken at any time.
// A held result (out_stall) stalls only the final hand-off; the next pair is
// accepted as soon as the result sits in the output register.
module gibbs_link_sweep_step_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] row_index,
  input  logic [15:0] col_index,
  input  logic signed [31:0] lla,
  input  logic signed [31:0] llb,
  input  logic signed [31:0] lll,
  input  logic [31:0] uniform_draw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        linked_after,
  output logic        changed,
  output logic signed [47:0] loglik_now,
  output logic [12:0] link_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int LLW = glss_pkg::LL_W;
  localparam int DW  = glss_pkg::DELTA_W;
  localparam logic signed [LLW:0] LL_MAX = {2'b00, {(LLW-1){1'b1}}};
  localparam logic signed [LLW:0] LL_MIN = {2'b11, {(LLW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EVAL, S_MATH, S_WRITE, S_DONE
  } state_t;

  state_t state;
  logic [glss_pkg::CLR_AW-1:0]   clr;
  logic [glss_pkg::ROW_IW-1:0]   row_r;
  logic [glss_pkg::COL_IW-1:0]   col_r;
  logic signed [glss_pkg::DSUM_W-1:0] dsum_r;
  logic [31:0]                   draw_r;
  logic                          add_r;
  logic                          del_r;
  logic signed [DW-1:0]          delta_r;
  logic                          res_linked;
  logic                          res_changed;
  logic [glss_pkg::NB_W-1:0]     nb_count;
  logic signed [31:0]            prior;
  logic signed [LLW-1:0]         run;
  logic [glss_pkg::CNT_W-1:0]    count;

  // stores
  logic                        row_we, col_we;
  logic [glss_pkg::ROW_AW-1:0] row_waddr, row_raddr;
  logic [glss_pkg::ROWW-1:0]   row_wdata, row_rd;
  logic [glss_pkg::COL_AW-1:0] col_waddr, col_raddr;
  logic [31:0]                 col_wdata, col_rd;

  glss_pkg::math_req_t mreq;
  glss_pkg::math_rsp_t mrsp;

  logic        in_range, row_lk, col_lk, add, del;
  logic [4:0]  lane;
  logic signed [19:0] nsig;
  logic signed [LLW:0] vsum;

  glss_ram #(.WIDTH(glss_pkg::ROWW), .DEPTH(glss_pkg::ROWS_A)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rd)
  );

  glss_ram #(.WIDTH(32), .DEPTH(glss_pkg::COL_WORDS)) u_col_ram (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rd)
  );

  glss_math u_math (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != S_IDLE);

  always_comb begin
    lane      = col_r[4:0];
    row_raddr = glss_pkg::ROW_AW'(row_r);
    col_raddr = glss_pkg::COL_AW'(col_r >> 5);
    in_range  = (32'(row_r) < 32'(glss_pkg::ROWS_A)) &&
                (32'(col_r) < 32'(glss_pkg::COLS_B));
    row_lk    = row_rd[glss_pkg::ROWW-1];
    col_lk    = col_rd[lane];
    add       = in_range && !row_lk && !col_lk;
    del       = in_range && row_lk && (row_rd[glss_pkg::COL_IW-1:0] == col_r);

    // free count; below one it is taken as one
    nsig = 20'(nb_count) - 20'(count) + 20'(del);
    mreq.start = (state == S_EVAL) && (add || del);
    mreq.n     = (nsig < 20'sd1) ? glss_pkg::N_W'(1) : glss_pkg::N_W'(nsig);
    mreq.dsum  = dsum_r;
    mreq.del   = del;
    mreq.draw  = draw_r;

    vsum = (LLW+1)'(run) + (LLW+1)'(delta_r);

    if (state == S_CLEAR) begin
      row_we    = (32'(clr) < 32'(glss_pkg::ROWS_A));
      col_we    = (32'(clr) < 32'(glss_pkg::COL_WORDS));
      row_waddr = glss_pkg::ROW_AW'(clr);
      col_waddr = glss_pkg::COL_AW'(clr);
      row_wdata = '0;
      col_wdata = '0;
    end else begin
      row_we    = (state == S_WRITE);
      col_we    = (state == S_WRITE);
      row_waddr = row_raddr;
      col_waddr = col_raddr;
      row_wdata = add_r ? {1'b1, col_r} : '0;
      col_wdata = col_rd;
      col_wdata[lane] = add_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      nb_count  <= glss_pkg::NB_W'(65536);
      prior     <= '0;
      run       <= '0;
      count     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          glss_pkg::CFG_NB_COUNT: nb_count <= cfg_data[glss_pkg::NB_W-1:0];
          glss_pkg::CFG_PRIOR:    prior    <= cfg_data[31:0];
          glss_pkg::CFG_START_LL: run      <= cfg_data;
          default: ;
        endcase
      end

      // output register: load a finished step, or drop a taken transaction
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == 32'(glss_pkg::CLR_LEN - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            row_r  <= row_index;
            col_r  <= col_index;
            dsum_r <= glss_pkg::DSUM_W'(prior) + glss_pkg::DSUM_W'(lll)
                    - glss_pkg::DSUM_W'(lla) - glss_pkg::DSUM_W'(llb);
            draw_r <= uniform_draw;
            state  <= S_READ;
          end
        end
        S_READ: state <= S_EVAL;   // store read in flight
        S_EVAL: begin
          add_r <= add;
          del_r <= del;
          if (add || del) begin
            state <= S_MATH;
          end else begin
            // busy elsewhere or out of range: nothing changes
            res_linked  <= 1'b0;
            res_changed <= 1'b0;
            state       <= S_DONE;
          end
        end
        S_MATH: begin
          if (mrsp.done) begin
            delta_r <= mrsp.delta;
            if (mrsp.accept) begin
              state <= S_WRITE;
            end else begin
              res_linked  <= del_r;
              res_changed <= 1'b0;
              state       <= S_DONE;
            end
          end
        end
        S_WRITE: begin
          if (vsum > LL_MAX)      run <= LL_MAX[LLW-1:0];
          else if (vsum < LL_MIN) run <= LL_MIN[LLW-1:0];
          else                    run <= vsum[LLW-1:0];
          count       <= add_r ? count + 1'b1 : count - 1'b1;
          res_linked  <= add_r;
          res_changed <= 1'b1;
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            linked_after <= res_linked;
            changed      <= res_changed;
            loglik_now   <= run;
            link_total   <= count;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sim/tb_top.sv
module tb_top;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [11:0] row_index;
  logic [15:0] col_index;
  logic signed [31:0] lla, llb, lll;
  logic [31:0] uniform_draw;
  logic out_valid;
  logic out_stall;
  logic linked_after, changed;
  logic signed [47:0] loglik_now;
  logic [12:0] link_total;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [47:0] cfg_data;

  gibbs_link_sweep_step_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .row_index(row_index), .col_index(col_index),
    .lla(lla), .llb(llb), .lll(lll), .uniform_draw(uniform_draw),
    .out_valid(out_valid), .out_stall(out_stall),
    .linked_after(linked_after), .changed(changed),
    .loglik_now(loglik_now), .link_total(link_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // One expected step outcome.
  typedef struct {
    logic        linked;
    logic        chg;
    logic [47:0] ll;
    logic [12:0] cnt;
  } step_out_t;

  // Directed row: pair fields plus an optional typed-in expectation.
  typedef struct {
    logic [11:0] r;
    logic [15:0] c;
    logic [31:0] a, b, l, u;
    bit          fixed;
    step_out_t   want;
  } pair_row_t;

  localparam longint LL_HI = 64'sd140737488355327;
  localparam longint LL_LO = -64'sd140737488355328;
  localparam int LIMIT = 2_000_000;

  // Predictor state: own copy of the link stores and registers.
  bit             row_on [glss_pkg::ROWS_A];
  logic [15:0]    row_mate [glss_pkg::ROWS_A];
  bit             col_on [glss_pkg::COLS_B];
  int             links;
  longint         loglik_acc;
  int             nb_reg;
  longint         prior_reg;

  step_out_t      pending_steps[$];
  pair_row_t      dir_rows[$];
  int             errors = 0;
  int             cycles = 0;
  int             snd_idle_pct, rcv_idle_pct;
  bit             hold_rx;
  logic [31:0]    sqrt_tab [1:glss_pkg::FRAC_BITS];

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] v, res, b;
    v = x;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // natural log of a count, Q.FRAC_BITS
  function automatic longint count_ln(input int n);
    int k;
    logic [63:0] y, fr, lg;
    logic [127:0] prod;
    k = 0;
    fr = 0;
    while (((n >> (k + 1)) != 0) && k < 31) k++;
    y = 64'(n) << (31 - k);
    for (int i = 0; i < 24; i++) begin
      y = (y * y) >> 31;
      fr = fr << 1;
      if (y >= 64'h1_0000_0000) begin
        fr = fr | 1;
        y = y >> 1;
      end
    end
    lg = (64'(k) << 24) | fr;
    prod = 128'(lg) * 128'(glss_pkg::LN2_Q32) + (128'd1 << (55 - glss_pkg::FRAC_BITS));
    return longint'(prod >> (56 - glss_pkg::FRAC_BITS));
  endfunction

  // acceptance threshold, Q0.32 (value 2^32 possible)
  function automatic logic [63:0] accept_level(input longint d);
    logic [63:0] a, t, ti, tf, m, e, q;
    a = (d < 0) ? -d : d;
    if (a > (64'd40 << glss_pkg::FRAC_BITS)) a = 64'd40 << glss_pkg::FRAC_BITS;
    t = (a * 64'(glss_pkg::LOG2E_Q30)) >> 30;
    ti = t >> glss_pkg::FRAC_BITS;
    tf = t & ((64'd1 << glss_pkg::FRAC_BITS) - 1);
    m = 64'd1 << 32;
    for (int i = 1; i <= glss_pkg::FRAC_BITS; i++)
      if ((tf >> (glss_pkg::FRAC_BITS - i)) & 1) m = (m * 64'(sqrt_tab[i])) >> 32;
    e = (ti >= 32) ? 0 : (m >> ti);
    q = 2 * ((64'd1 << 63) / ((64'd1 << 32) + e));
    return (d >= 0) ? q : (64'd1 << 32) - q;
  endfunction

  function automatic step_out_t link_step(input pair_row_t p);
    step_out_t o;
    bit add, del;
    longint n, delta, v;
    o.linked = 0;
    o.chg = 0;
    add = !row_on[p.r] && !col_on[p.c];
    del = row_on[p.r] && row_mate[p.r] == p.c;
    if (add || del) begin
      n = longint'(nb_reg) - links + (del ? 1 : 0);
      if (n < 1) n = 1;
      delta = -longint'($signed(p.b)) - longint'($signed(p.a)) + longint'($signed(p.l))
              + prior_reg - count_ln(int'(n));
      if (del) delta = -delta;
      if (64'(p.u) < accept_level(delta)) begin
        v = loglik_acc + delta;
        loglik_acc = (v > LL_HI) ? LL_HI : ((v < LL_LO) ? LL_LO : v);
        o.chg = 1;
        if (add) begin
          row_on[p.r] = 1;
          row_mate[p.r] = p.c;
          col_on[p.c] = 1;
          links++;
        end else begin
          row_on[p.r] = 0;
          row_mate[p.r] = 0;
          col_on[p.c] = 0;
          links--;
        end
      end
      o.linked = row_on[p.r] && row_mate[p.r] == p.c;
    end
    o.ll = loglik_acc[47:0];
    o.cnt = links[12:0];
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Receiver: random stall, with an optional long hold-off.
  always @(posedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= hold_rx || ($urandom_range(99) < rcv_idle_pct);
  end

  // Result checker: compare each transaction against the oldest expectation.
  always @(posedge clk) begin
    step_out_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_steps.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        w = pending_steps.pop_front();
        if (linked_after !== w.linked) begin
          $error("linked_after: expected %0d actual %0d", w.linked, linked_after);
          errors++;
        end
        if (changed !== w.chg) begin
          $error("changed: expected %0d actual %0d", w.chg, changed);
          errors++;
        end
        if (loglik_now !== w.ll) begin
          $error("loglik_now: expected %h actual %h", w.ll, loglik_now);
          errors++;
        end
        if (link_total !== w.cnt) begin
          $error("link_total: expected %0d actual %0d", w.cnt, link_total);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [47:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      glss_pkg::CFG_NB_COUNT: nb_reg = int'(val[16:0]);
      glss_pkg::CFG_PRIOR:    prior_reg = longint'($signed(val[31:0]));
      glss_pkg::CFG_START_LL: loglik_acc = longint'($signed(val));
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pair; the expectation is queued at acceptance. in_valid stays
  // high afterwards so that pairs can follow back to back.
  task automatic offer_pair(input pair_row_t p);
    step_out_t o;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    row_index <= p.r;
    col_index <= p.c;
    lla <= p.a;
    llb <= p.b;
    lll <= p.l;
    uniform_draw <= p.u;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    o = link_step(p);
    if (p.fixed && (o.linked !== p.want.linked || o.chg !== p.want.chg ||
        o.cnt !== p.want.cnt)) begin
      $error("directed row table disagrees with predictor");
      errors++;
    end
    pending_steps.insert(pending_steps.size(), o);
  endtask

  task automatic drain_out();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic void add_row(input pair_row_t p);
    dir_rows.insert(dir_rows.size(), p);
  endfunction

  function automatic pair_row_t mk(input logic [11:0] r, input logic [15:0] c,
                                   input logic [31:0] a, b, l, u);
    pair_row_t p;
    p.r = r; p.c = c; p.a = a; p.b = b; p.l = l; p.u = u;
    p.fixed = 0;
    p.want = '{0, 0, 0, 0};
    return p;
  endfunction

  function automatic pair_row_t rand_pair(input int span_r, input int span_c);
    pair_row_t p;
    int mode;
    mode = $urandom_range(9);
    p = mk(12'($urandom_range(span_r)), 16'($urandom_range(span_c)),
           $urandom, $urandom, $urandom, $urandom);
    // mostly moderate terms so acceptance is a real coin flip
    if (mode < 7) begin
      p.a = $signed($urandom_range(8 << 16)) - (4 << 16);
      p.b = $signed($urandom_range(8 << 16)) - (4 << 16);
      p.l = $signed($urandom_range(8 << 16)) - (4 << 16);
    end
    // revisit an existing link to exercise the break path
    if (mode < 4 && links > 0) begin
      for (int k = 0; k < 8; k++) begin
        p.r = 12'($urandom_range(span_r));
        if (row_on[p.r]) begin
          p.c = row_mate[p.r];
          break;
        end
      end
    end
    return p;
  endfunction

  initial begin
    pair_row_t p;
    int span_r, span_c;
    hold_rx = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    rst = 1;
    in_valid = 0;
    row_index = 0; col_index = 0; lla = 0; llb = 0; lll = 0; uniform_draw = 0;
    cfg_valid = 0; cfg_index = glss_pkg::CFG_NB_COUNT; cfg_data = 0;
    sqrt_tab[1] = root_floor(64'h8000_0000_0000_0000);
    for (int i = 2; i <= glss_pkg::FRAC_BITS; i++)
      sqrt_tab[i] = root_floor({sqrt_tab[i-1], 32'd0});
    for (int i = 0; i < glss_pkg::ROWS_A; i++) begin
      row_on[i] = 0;
      row_mate[i] = 0;
    end
    for (int i = 0; i < glss_pkg::COLS_B; i++) col_on[i] = 0;
    links = 0; loglik_acc = 0; nb_reg = 65536; prior_reg = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed table: draw 0 accepts a proposal unless the threshold is zero, draw
    // max never does unless the threshold is saturated at one.
    p = mk(0, 0, 0, 0, 32'h7FFF_FFFF, 0);           // free pair, certain link
    p.fixed = 1; p.want = '{1, 1, 0, 1}; add_row(p);
    p = mk(0, 1, 0, 0, 0, 0);                      // row busy elsewhere
    p.fixed = 1; p.want = '{0, 0, 0, 1}; add_row(p);
    p = mk(1, 0, 0, 0, 0, 0);                      // column busy elsewhere
    p.fixed = 1; p.want = '{0, 0, 0, 1}; add_row(p);
    p = mk(0, 0, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF); // keep the link
    p.fixed = 1; p.want = '{1, 0, 0, 1}; add_row(p);
    p = mk(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0); // break it
    p.fixed = 1; p.want = '{0, 1, 0, 0}; add_row(p);
    p = mk(12'hFFF, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    p.fixed = 1; p.want = '{1, 1, 0, 1}; add_row(p);
    p = mk(12'hFFF, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
           32'hFFFF_FFFF);
    add_row(p);
    add_row(mk(5, 7, 0, 0, 0, 32'h8000_0000));   // draw at one half
    add_row(mk(6, 8, 32'h0001_0000, 0, 0, 32'h4000_0000));
    add_row(mk(7, 9, 0, 32'hFFFF_0000, 32'h0000_8000, 32'hC000_0000));
    add_row(mk(12'hAAA, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA,
               32'h5555_5555, 32'h5555_5555));
    add_row(mk(12'h555, 16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555,
               32'hAAAA_AAAA, 32'hAAAA_AAAA));

    snd_idle_pct = 19; rcv_idle_pct = 56;
    foreach (dir_rows[i]) offer_pair(dir_rows[i]);
    drain_out();

    // Count not positive: tiny nb_count, large prior, a new start total.
    reg_write(glss_pkg::CFG_NB_COUNT, 48'd1);
    reg_write(glss_pkg::CFG_PRIOR, 48'h0000_7FFF_FFFF);
    reg_write(glss_pkg::CFG_START_LL, 48'h7FFF_FFFF_0000);
    // Running total overflow: many certain links near the top.
    for (int i = 0; i < 10; i++)
      offer_pair(mk(12'(100 + i), 16'(200 + i), 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 0));
    drain_out();
    reg_write(glss_pkg::CFG_PRIOR, 48'hFFFF_8000_0000);
    reg_write(glss_pkg::CFG_START_LL, 48'h8000_0000_0000);
    for (int i = 0; i < 10; i++)
      offer_pair(mk(12'(100 + i), 16'(200 + i), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 0));
    drain_out();

    // Random phases under several register settings; small index ranges
    // give frequent collisions and breaks.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(glss_pkg::CFG_NB_COUNT, 48'd65536);
          reg_write(glss_pkg::CFG_PRIOR, 48'd0);
        end
        1: reg_write(glss_pkg::CFG_NB_COUNT, 48'd20);
        2: reg_write(glss_pkg::CFG_PRIOR, 48'hFFFF_FFFD_0000);
        3: reg_write(glss_pkg::CFG_NB_COUNT, 48'd131071);
        4: reg_write(glss_pkg::CFG_PRIOR, 48'h0000_0004_0000);
        default: reg_write(glss_pkg::CFG_NB_COUNT, 48'd300);
      endcase
      reg_write(glss_pkg::CFG_START_LL, {16'($urandom_range(65535)), $urandom});
      if (ph == 2) begin
        snd_idle_pct = 56; rcv_idle_pct = 19;
      end
      if (ph == 4) begin
        snd_idle_pct = 0; rcv_idle_pct = 0;
      end
      span_r = (ph % 2) ? 4095 : 31;
      span_c = (ph % 2) ? 65535 : 63;
      // Long receiver hold-off while the sender keeps offering.
      if (ph == 1) begin
        fork
          begin
            hold_rx = 1;
            repeat (600) @(posedge clk);
            hold_rx = 0;
          end
        join_none
      end
      for (int i = 0; i < 280; i++) begin
        // mid-phase, pause sending until all results are home
        if (i == 140) begin
          in_valid <= 1'b0;
          while (pending_steps.size() != 0) @(posedge clk);
        end
        offer_pair(rand_pair(span_r, span_c));
      end
      drain_out();
    end

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
